### sv/circular_deque_defines.svh
// Assertion macros used by the deque control block (cdq_ctrl)
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

// cond must hold at every edge outside reset
`define CDQ_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// cons must hold in the cycle after ante holds
`define CDQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/cdq_pkg.sv
package cdq_pkg;

   localparam int DEPTH     = 16;
   localparam int PtrW      = $clog2(DEPTH);
   localparam int CountW    = $clog2(DEPTH + 1);
   localparam int WordW     = 32;
   localparam int CountOutW = 5;

   localparam logic [WordW-1:0] EMPTY_WORD = '1;

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_REAR  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_REAR   = 2'd3
   } cdq_op_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } cdq_status_type;

   // what the control side hands to the output stage with each item
   typedef struct packed {
      cdq_status_type           status;
      logic                     fwd_front;
      logic                     fwd_rear;
      logic [WordW-1:0]         word;
      logic                     empty;
      logic [CountOutW-1:0]     count;
   } cdq_issue_type;

   function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
      return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
   endfunction

   function automatic logic [PtrW-1:0] ptr_prev(input logic [PtrW-1:0] p);
      return (p == '0) ? PtrW'(DEPTH - 1) : p - PtrW'(1);
   endfunction

endpackage

### sv/cdq_ifs.sv
interface cdq_req_if import cdq_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              operation;
   logic signed [WordW-1:0] data;

   modport source (output valid, output operation, output data, input ready);
   modport sink   (input valid, input operation, input data, output ready);
endinterface

interface cdq_rsp_if import cdq_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              status;
   logic signed [WordW-1:0] front_value;
   logic signed [WordW-1:0] rear_value;
   logic [CountOutW-1:0]    count;
   logic                    is_empty;

   modport source (output valid, output status, output front_value, output rear_value,
                   output count, output is_empty, input ready);
   modport sink   (input valid, input status, input front_value, input rear_value,
                   input count, input is_empty, output ready);
endinterface

### sv/cdq_ram.sv
module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_a_ff <= mem_ff[raddr_a];
         rdata_b_ff <= mem_ff[raddr_b];
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

### sv/cdq_ctrl.sv
`include "circular_deque_defines.svh"

module cdq_ctrl import cdq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   cdq_req_if.sink            req_if,
   input  logic               stage_free,
   output logic               issue,
   output cdq_issue_type      info,
   output logic               we,
   output logic [PtrW-1:0]    waddr,
   output logic [WordW-1:0]   wdata,
   output logic [PtrW-1:0]    raddr_front,
   output logic [PtrW-1:0]    raddr_rear
);

   logic [PtrW-1:0]   head_ff, head_in;
   logic [PtrW-1:0]   tail_ff, tail_in;
   logic [CountW-1:0] occ_ff, occ_in;
   cdq_op_type        op;
   cdq_status_type    status;
   logic              full, empty, fwd_front, fwd_rear;

   assign req_if.ready = stage_free;
   assign issue        = req_if.valid && req_if.ready;
   assign op           = cdq_op_type'(req_if.operation);
   assign full         = (occ_ff == CountW'(DEPTH));
   assign empty        = (occ_ff == '0);
   assign wdata        = req_if.data;

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      occ_in    = occ_ff;
      status    = ST_DONE;
      we        = 1'b0;
      waddr     = '0;
      fwd_front = 1'b0;
      fwd_rear  = 1'b0;
      unique case (op)
         OP_PUSH_FRONT, OP_PUSH_REAR: begin
            if (full) begin
               status = ST_OVERFLOW;
            end else begin
               we     = issue;
               occ_in = occ_ff + CountW'(1);
               if (empty) begin
                  head_in   = '0;
                  tail_in   = '0;
                  waddr     = '0;
                  fwd_front = 1'b1;
                  fwd_rear  = 1'b1;
               end else if (op == OP_PUSH_FRONT) begin
                  head_in   = ptr_prev(head_ff);
                  waddr     = head_in;
                  fwd_front = 1'b1;
               end else begin
                  tail_in  = ptr_next(tail_ff);
                  waddr    = tail_in;
                  fwd_rear = 1'b1;
               end
            end
         end
         OP_POP_FRONT, OP_POP_REAR: begin
            if (empty) begin
               status = ST_UNDERFLOW;
            end else if (occ_ff == CountW'(1)) begin
               head_in = '0;
               tail_in = '0;
               occ_in  = '0;
            end else begin
               if (op == OP_POP_FRONT) begin
                  head_in = ptr_next(head_ff);
               end else begin
                  tail_in = ptr_prev(tail_ff);
               end
               occ_in = occ_ff - CountW'(1);
            end
         end
         default: ;
      endcase
   end

   // read the new ends in the accept cycle; the pushed word is forwarded
   assign raddr_front = head_in;
   assign raddr_rear  = tail_in;

   always_comb begin
      info.status    = status;
      info.fwd_front = fwd_front;
      info.fwd_rear  = fwd_rear;
      info.word      = req_if.data;
      info.empty     = (occ_in == '0);
      info.count     = CountOutW'(occ_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         occ_ff  <= '0;
      end else if (issue) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff  <= occ_in;
      end
   end

   `CDQ_ASSERT_ALWAYS(a_occ_bound, clock, reset, occ_ff <= CountW'(DEPTH), "occupancy above depth")
   `CDQ_ASSERT_ALWAYS(a_empty_ptrs, clock, reset, (occ_ff != '0) || (head_ff == '0 && tail_ff == '0), "empty deque with nonzero pointers")
   `CDQ_ASSERT_NEXT(a_refused_hold, clock, reset, issue && status != ST_DONE, $stable(occ_ff) && $stable(head_ff) && $stable(tail_ff), "refused item changed state")

endmodule

### sv/cdq_out.sv
module cdq_out import cdq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               issue,
   input  cdq_issue_type      info,
   input  logic [WordW-1:0]   rd_front,
   input  logic [WordW-1:0]   rd_rear,
   output logic               stage_free,
   cdq_rsp_if.source          rsp_if
);

   logic                 s1_valid_ff, s1_valid_in;
   cdq_issue_type        s1_info_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           status_ff;
   logic [WordW-1:0]     front_ff, rear_ff;
   logic [CountOutW-1:0] count_ff;
   logic                 empty_ff;
   logic                 out_free, move;
   logic [WordW-1:0]     front_val, rear_val;

   assign out_free   = !rsp_valid_ff || rsp_if.ready;
   assign move       = s1_valid_ff && out_free;
   assign stage_free = !s1_valid_ff || out_free;

   always_comb begin
      s1_valid_in  = issue ? 1'b1 : (move ? 1'b0 : s1_valid_ff);
      rsp_valid_in = move ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);
      front_val    = s1_info_ff.fwd_front ? s1_info_ff.word : rd_front;
      rear_val     = s1_info_ff.fwd_rear  ? s1_info_ff.word : rd_rear;
      if (s1_info_ff.empty) begin
         front_val = EMPTY_WORD;
         rear_val  = EMPTY_WORD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_info_ff <= info;
      end
      if (move) begin
         status_ff <= s1_info_ff.status;
         front_ff  <= front_val;
         rear_ff   <= rear_val;
         count_ff  <= s1_info_ff.count;
         empty_ff  <= s1_info_ff.empty;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = status_ff;
   assign rsp_if.front_value = front_ff;
   assign rsp_if.rear_value  = rear_ff;
   assign rsp_if.count       = count_ff;
   assign rsp_if.is_empty    = empty_ff;

endmodule

### sv/circular_deque.sv
// Pipeline: an accepted request item passes the storage read and s1 register,
// then the output register, which holds its result; an output stall can hold it in s1.
// Throughput: one item per cycle unless the output stalls; the RAM does one write and
// two reads (new front, rear) each cycle; a stalled result backs up after two items.
// Reset: head, tail and count clear to zero (empty deque); storage is not
// cleared and needs no clearing pass, since only held entries are ever shown.
module circular_deque import cdq_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   cdq_req_if.sink   req_if,
   cdq_rsp_if.source rsp_if
);

   logic            issue, stage_free, we;
   cdq_issue_type   info;
   logic [PtrW-1:0] waddr, raddr_front, raddr_rear;
   logic [WordW-1:0] wdata, rd_front, rd_rear;

   cdq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .stage_free  (stage_free),
      .issue       (issue),
      .info        (info),
      .we          (we),
      .waddr       (waddr),
      .wdata       (wdata),
      .raddr_front (raddr_front),
      .raddr_rear  (raddr_rear)
   );

   cdq_ram #(
      .WIDTH (WordW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .we      (we),
      .waddr   (waddr),
      .wdata   (wdata),
      .re      (issue),
      .raddr_a (raddr_front),
      .raddr_b (raddr_rear),
      .rdata_a (rd_front),
      .rdata_b (rd_rear)
   );

   cdq_out u_out (
      .clock      (clock),
      .reset      (reset),
      .issue      (issue),
      .info       (info),
      .rd_front   (rd_front),
      .rd_rear    (rd_rear),
      .stage_free (stage_free),
      .rsp_if     (rsp_if)
   );

endmodule
